// File: src/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for the inverter supervisor
// Item layouts, supervisor state, thresholds and the scale factor table.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int AMP_W     = 10;
  localparam int MAINS_W   = 19;
  localparam int BATT_W    = 20;
  localparam int MA_W      = 16;
  localparam int FAULT_W   = 12;
  localparam int CVAL_W    = 8;
  localparam int PCT_W     = 7;
  localparam int FACTOR_W  = 24;
  localparam int SCALE_SH  = 24;
  localparam int PROD_W    = AMP_W + FACTOR_W;

  localparam logic [MAINS_W-1:0]  MAINS_FAIL_MV  = MAINS_W'(198000);
  localparam logic [BATT_W-1:0]   BATT_LOW_MV    = BATT_W'(300000);
  localparam logic signed [MA_W-1:0] CURRENT_MAX_MA = MA_W'(6000);
  localparam logic [AMP_W-1:0]    SOFT_STEP      = AMP_W'(5);
  localparam logic [AMP_W-1:0]    AMP_MAX        = '1;
  localparam logic [PCT_W-1:0]    SCALE_LO       = PCT_W'(5);
  localparam logic [PCT_W-1:0]    SCALE_HI       = PCT_W'(95);
  // ceil(2^24 / 100): x * RECIP >> 24 == x / 100 for every product in range
  localparam logic [FACTOR_W-1:0] SCALE_RECIP    = FACTOR_W'(167773);

  localparam logic [AMP_W-1:0]    MIN_AMP_RST    = AMP_W'(20);
  localparam logic [AMP_W-1:0]    MAX_AMP_RST    = AMP_W'(200);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_CHARGE = 2'd2,
    KIND_SCALE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MANUAL  = 2'd0,
    REG_MIN_AMP = 2'd1,
    REG_MAX_AMP = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             manual_mode;
    logic [AMP_W-1:0] min_amplitude;
    logic [AMP_W-1:0] max_amplitude;
  } cfg_t;

  typedef struct packed {
    logic             run_cmd;
    logic             charge_cmd;
    logic             soft_done;
    logic [AMP_W-1:0] amp_now;
  } state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [MAINS_W-1:0]     mains_mv;
    logic [BATT_W-1:0]      battery_mv;
    logic signed [MA_W-1:0] battery_ma;
    logic [FAULT_W-1:0]     cell_faults;
    logic                   inverter_ok;
    logic [CVAL_W-1:0]      command_value;
  } item_t;

  typedef struct packed {
    logic             amplitude_write;
    logic [AMP_W-1:0] amplitude_value;
  } amp_msg_t;

  // percent times the reciprocal of 100, a constant table over 5..95
  function automatic logic [FACTOR_W-1:0] scale_factor(input logic [PCT_W-1:0] pct);
    logic [FACTOR_W+PCT_W-1:0] prod;
    prod = {{FACTOR_W{1'b0}}, pct} * {{PCT_W{1'b0}}, SCALE_RECIP};
    return prod[FACTOR_W-1:0];
  endfunction

endpackage

// File: src/iss_core.sv
// ----------------------------------------------------------------------------
// iss_core: supervisor next-state logic
// Applies one tick or command to the supervisor state and forms the
// amplitude message for the sine generator.
// ----------------------------------------------------------------------------
module iss_core (
  input  iss_pkg::cfg_t     cfg,
  input  iss_pkg::state_t   st_i,
  input  iss_pkg::item_t    item,
  output iss_pkg::state_t   st_o,
  output iss_pkg::amp_msg_t msg_o
);

  logic [iss_pkg::PCT_W-1:0]    pct;
  logic [iss_pkg::PROD_W-1:0]   scaled;
  logic                         cmd_on;
  logic                         want_inv;
  logic                         want_chg;
  logic [iss_pkg::AMP_W:0]      ramp_sum;

  // clamp 0..255 percent to 5..95
  always_comb begin
    if (item.command_value > iss_pkg::CVAL_W'(iss_pkg::SCALE_HI)) begin
      pct = iss_pkg::SCALE_HI;
    end else if (item.command_value < iss_pkg::CVAL_W'(iss_pkg::SCALE_LO)) begin
      pct = iss_pkg::SCALE_LO;
    end else begin
      pct = item.command_value[iss_pkg::PCT_W-1:0];
    end
  end

  assign scaled = {{iss_pkg::FACTOR_W{1'b0}}, cfg.max_amplitude}
                * {{iss_pkg::AMP_W{1'b0}}, iss_pkg::scale_factor(pct)};

  assign cmd_on = (item.command_value != '0);

  always_comb begin
    want_inv = 1'b1;
    want_chg = 1'b1;
    if (item.cell_faults != '0) begin
      if (item.battery_ma < 0) begin
        want_chg = 1'b0;
      end else begin
        want_inv = 1'b0;
      end
    end
    if (!item.inverter_ok) want_inv = 1'b0;
    if (item.battery_mv < iss_pkg::BATT_LOW_MV) want_inv = 1'b0;
  end

  always_comb begin
    st_o     = st_i;
    msg_o    = '0;
    ramp_sum = '0;
    case (item.kind)
      iss_pkg::KIND_RUN: begin
        if (cfg.manual_mode) begin
          st_o.run_cmd = cmd_on;
          if (!cmd_on) begin
            st_o.soft_done = 1'b0;
            st_o.amp_now   = cfg.min_amplitude;
          end
        end
      end
      iss_pkg::KIND_CHARGE: begin
        st_o.charge_cmd = cmd_on;
      end
      iss_pkg::KIND_SCALE: begin
        msg_o.amplitude_write = 1'b1;
        msg_o.amplitude_value = scaled[iss_pkg::SCALE_SH +: iss_pkg::AMP_W];
      end
      default: begin
        // supervisory tick
        if (!cfg.manual_mode) begin
          if (item.mains_mv < iss_pkg::MAINS_FAIL_MV) begin
            if (want_inv) begin
              if (!st_o.soft_done) st_o.run_cmd = 1'b1;
            end else begin
              st_o.run_cmd   = 1'b0;
              st_o.soft_done = 1'b0;
              st_o.amp_now   = cfg.min_amplitude;
            end
            st_o.charge_cmd = want_chg;
            // steady-state trim by one unit
            if (st_o.soft_done) begin
              if (item.battery_ma > iss_pkg::CURRENT_MAX_MA) begin
                if (st_o.amp_now > cfg.min_amplitude) begin
                  st_o.amp_now          = st_o.amp_now - iss_pkg::AMP_W'(1);
                  msg_o.amplitude_write = 1'b1;
                  msg_o.amplitude_value = st_o.amp_now;
                end
              end else if (st_o.amp_now < cfg.max_amplitude) begin
                st_o.amp_now          = st_o.amp_now + iss_pkg::AMP_W'(1);
                msg_o.amplitude_write = 1'b1;
                msg_o.amplitude_value = st_o.amp_now;
              end
            end
          end else begin
            st_o.run_cmd    = 1'b0;
            st_o.soft_done  = 1'b0;
            st_o.amp_now    = cfg.min_amplitude;
            st_o.charge_cmd = 1'b0;
          end
        end
        // soft start ramp
        if (st_o.run_cmd && !st_o.soft_done) begin
          if (st_o.amp_now <= cfg.max_amplitude &&
              item.battery_ma <= iss_pkg::CURRENT_MAX_MA) begin
            msg_o.amplitude_write = 1'b1;
            msg_o.amplitude_value = st_o.amp_now;
            ramp_sum = {1'b0, st_o.amp_now} + {1'b0, iss_pkg::SOFT_STEP};
            if (ramp_sum[iss_pkg::AMP_W]) begin
              st_o.amp_now = iss_pkg::AMP_MAX;
            end else begin
              st_o.amp_now = ramp_sum[iss_pkg::AMP_W-1:0];
            end
          end else begin
            st_o.soft_done = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

// File: src/inverter_supervisor_soft_start.sv
// ----------------------------------------------------------------------------
// inverter_supervisor_soft_start: backup inverter and charger supervisor
// Mains-failure control, soft start ramp, current-limit trim and scale
// commands, one result item for every input item.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  in_      slave      in_tvalid / in_tready    in_tuser kind, in_tdata fields
//  out_     master     out_tvalid / out_tready  out_tdata status and amplitude
//  cfg_     slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  An item is taken into the input register, then, once the result register
//  is empty or being drained, it runs through the supervisor logic into the
//  result register and the state. out_tvalid rises once the item has passed
//  the two register stages, input and result; while out_tready stays high one
//  item per cycle is sustained, the limit being the single state update per cycle.
//  Reset (rst_n low, synchronous) clears the flags, sets amplitude to 20, loads
//  the register defaults (min 20, max 200, automatic mode), empties both stages.
//  A stall on out_tready holds the result register; the input register keeps
//  accepting until it too is full, then in_tready drops.
//  cfg_ready is always high.
//
module inverter_supervisor_soft_start (
  input  logic        clk,
  input  logic        rst_n,
  // slave item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [18:0] mains_mv, [38:19] battery_mv, [54:39] battery_ma,
  // [66:55] cell_faults, [67] inverter_ok, [75:68] command_value, [79:76] zero
  input  logic [79:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  // master result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] run_inverter, [1] run_charger, [2] inverter_ready,
  // [3] amplitude_write, [13:4] amplitude_value, [15:14] zero
  output logic [15:0] out_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  iss_pkg::cfg_t     cfg_r;
  iss_pkg::state_t   st_r;
  iss_pkg::state_t   st_nxt;
  iss_pkg::item_t    item_r;
  iss_pkg::amp_msg_t msg_nxt;
  iss_pkg::amp_msg_t msg_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;

  // input stage moves on when the result register is empty or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manual_mode   <= 1'b0;
      cfg_r.min_amplitude <= iss_pkg::MIN_AMP_RST;
      cfg_r.max_amplitude <= iss_pkg::MAX_AMP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        iss_pkg::REG_MANUAL:  cfg_r.manual_mode   <= cfg_data[0];
        iss_pkg::REG_MIN_AMP: cfg_r.min_amplitude <= cfg_data;
        iss_pkg::REG_MAX_AMP: cfg_r.max_amplitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind          <= iss_pkg::kind_t'(in_tuser);
      item_r.mains_mv      <= in_tdata[18:0];
      item_r.battery_mv    <= in_tdata[38:19];
      item_r.battery_ma    <= in_tdata[54:39];
      item_r.cell_faults   <= in_tdata[66:55];
      item_r.inverter_ok   <= in_tdata[67];
      item_r.command_value <= in_tdata[75:68];
    end
  end

  iss_core u_core (
    .cfg   (cfg_r),
    .st_i  (st_r),
    .item  (item_r),
    .st_o  (st_nxt),
    .msg_o (msg_nxt)
  );

  // supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.run_cmd    <= 1'b0;
      st_r.charge_cmd <= 1'b0;
      st_r.soft_done  <= 1'b0;
      st_r.amp_now    <= iss_pkg::MIN_AMP_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register; status bits come from st_r after the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      msg_r <= msg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, msg_r.amplitude_value, msg_r.amplitude_write,
                       st_r.soft_done, st_r.charge_cmd, st_r.run_cmd};

  // soft start can only have finished with the inverter running
  a_ready_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.soft_done |-> st_r.run_cmd)
    else $error("inverter_ready set while inverter is off");

  // a silent result carries a zero amplitude
  a_quiet_amp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !msg_r.amplitude_write) |-> (msg_r.amplitude_value == '0))
    else $error("amplitude without write strobe");

  // an empty result stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // state only moves when an item advances
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(st_r))
    else $error("state changed without an item");

endmodule
